[design/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// gpe_pkg: shared types and constants for the path search unit
// Holds the sequencer state type, the opcode codes and the fixed field widths.
// ----------------------------------------------------------------------------
package gpe_pkg;

	// Fixed widths of the stream fields and the vertex count register.
	localparam int VTX_W = 6;
	localparam int CNT_W = 7;

	// Vertex count after reset.
	localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

	// Opcode carried in tuser.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Search sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK,
		ST_PUSH,
		ST_DONE
	} gpe_state_t;

endpackage

[design/gpe_pick.sv]
// ----------------------------------------------------------------------------
// gpe_pick: lowest set bit picker
// Finds the lowest set bit of a candidate vector and returns its index.
// ----------------------------------------------------------------------------
module gpe_pick #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0]         vec,
	output logic                     found,
	output logic [$clog2(WIDTH)-1:0] idx
);

	localparam int IW = $clog2(WIDTH);

	// Scan from the top so that the lowest set bit wins.
	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				found = 1'b1;
				idx   = IW'(i);
			end
		end
	end

endmodule

[design/graph_path_exists_dfs_unit.sv]
// ----------------------------------------------------------------------------
// graph_path_exists_dfs_unit: directed graph reachability by depth-first search
// Stores an adjacency bit matrix loaded entry by entry and answers whether a
// target vertex can be reached from a source vertex.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload (lowest bit first)
//  ---------+-----------+----------------------------------------------------
//  s_*      | in        | tdata: from_vertex, to_vertex, edge_present; tuser: opcode
//  m_*      | out       | tdata: path_exists, bad_vertex
//  cfg_*    | in        | data: vertex_count
//
// An edge write leaves the input ready. A query walks the graph one visited
// vertex at a time: a stack pop, an adjacency row read, then one push per
// unvisited neighbor found by the single lowest-bit picker and one step that
// finds none. The vertex count in use is capped at MAX_VERTICES. A bad-vertex
// query goes straight to the result. Reset clears the matrix through per-row
// valid bits, so no clearing pass is needed. A stalled result waits in the
// output register while edge writes and the next query go on; a second
// result waits in the sequencer.
//
module graph_path_exists_dfs_unit #(
	parameter int MAX_VERTICES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [5:0] from_vertex, [11:6] to_vertex, [12] edge_present
	input  logic [0:0]  s_tuser,   // [0] opcode
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] path_exists, [1] bad_vertex
	// Vertex count register
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data   // [6:0] vertex_count
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int DW = $clog2(MAX_VERTICES + 1);
	localparam int EW = ($clog2(MAX_VERTICES + 1) > gpe_pkg::CNT_W) ?
		$clog2(MAX_VERTICES + 1) : gpe_pkg::CNT_W;

	// Input field split.
	logic [gpe_pkg::VTX_W-1:0] in_from;
	logic [gpe_pkg::VTX_W-1:0] in_to;
	logic                      in_edge;
	logic                      in_op;

	assign in_from = s_tdata[5:0];
	assign in_to   = s_tdata[11:6];
	assign in_edge = s_tdata[12];
	assign in_op   = s_tuser[0];

	// State.
	gpe_pkg::gpe_state_t       state_q, state_d;
	logic [gpe_pkg::CNT_W-1:0] cnt_q;
	logic [DW-1:0]             depth_q;
	logic [MAX_VERTICES-1:0]   visited_q;
	logic [VW-1:0]             dst_q;
	logic                      path_q;
	logic                      bad_q;
	logic [VW-1:0]             stk_rd_q;
	logic [MAX_VERTICES-1:0]   adj_rd_q;
	logic                      adj_rd_vld_q;
	logic [MAX_VERTICES-1:0]   row_vld_q;
	logic                      m_tvalid_q;
	logic [1:0]                m_data_q;

	// Memories: adjacency rows and search stack.
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [VW-1:0]           stk_mem [MAX_VERTICES];

	// Control strobes.
	logic in_acc;
	logic is_query;
	logic q_bad;
	logic wr_ok;
	logic st_empty;
	logic v_hit;
	logic out_free;
	logic ld_start;
	logic ld_bad;
	logic pop_go;
	logic row_go;
	logic push_go;
	logic out_load;

	// Search datapath.
	logic [EW-1:0]           eff_cnt;
	logic [MAX_VERTICES-1:0] cnt_mask;
	logic [MAX_VERTICES-1:0] row_data;
	logic [MAX_VERTICES-1:0] cand;
	logic                    pick_found;
	logic [VW-1:0]           pick_idx;
	logic [DW-1:0]           depth_m1;
	logic [VW-1:0]           wr_row;
	logic [VW-1:0]           wr_col;
	logic [VW-1:0]           src_v;
	logic [MAX_VERTICES-1:0] wr_init;
	logic [MAX_VERTICES-1:0] src_bit;

	// Effective vertex count and the mask of vertices in use.
	always_comb begin
		eff_cnt = (EW'(cnt_q) > EW'(MAX_VERTICES)) ? EW'(MAX_VERTICES) : EW'(cnt_q);
		for (int i = 0; i < MAX_VERTICES; i++) begin
			cnt_mask[i] = (EW'(i) < eff_cnt);
		end
	end

	assign in_acc   = s_tvalid && s_tready;
	assign is_query = (in_op == gpe_pkg::OP_QUERY);
	assign q_bad    = (EW'(in_from) >= eff_cnt) || (EW'(in_to) >= eff_cnt);
	assign wr_ok    = (32'(in_from) < MAX_VERTICES) && (32'(in_to) < MAX_VERTICES);
	assign wr_row   = VW'(in_from);
	assign wr_col   = VW'(in_to);
	assign src_v    = VW'(in_from);
	assign st_empty = (depth_q == '0);
	assign depth_m1 = depth_q - DW'(1);
	assign v_hit    = (stk_rd_q == dst_q);
	assign out_free = !m_tvalid_q || m_tready;

	// Row contents for a first write into a row, and the visited set seed.
	assign wr_init = MAX_VERTICES'(in_edge) << wr_col;
	assign src_bit = MAX_VERTICES'(1) << src_v;

	// Unvisited neighbors of the vertex being expanded.
	assign row_data = adj_rd_vld_q ? adj_rd_q : '0;
	assign cand     = row_data & ~visited_q & cnt_mask;

	gpe_pick #(
		.WIDTH(MAX_VERTICES)
	) u_pick (
		.vec  (cand),
		.found(pick_found),
		.idx  (pick_idx)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gpe_pkg::ST_IDLE: begin
				if (in_acc && is_query) begin
					state_d = q_bad ? gpe_pkg::ST_DONE : gpe_pkg::ST_POP;
				end
			end
			gpe_pkg::ST_POP: begin
				state_d = st_empty ? gpe_pkg::ST_DONE : gpe_pkg::ST_CHECK;
			end
			gpe_pkg::ST_CHECK: begin
				state_d = v_hit ? gpe_pkg::ST_DONE : gpe_pkg::ST_PUSH;
			end
			gpe_pkg::ST_PUSH: begin
				if (!pick_found) begin
					state_d = gpe_pkg::ST_POP;
				end
			end
			gpe_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = gpe_pkg::ST_IDLE;
				end
			end
			default: state_d = gpe_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = 1'b0;
		ld_start = 1'b0;
		ld_bad   = 1'b0;
		pop_go   = 1'b0;
		row_go   = 1'b0;
		push_go  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			gpe_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ld_start = in_acc && is_query && !q_bad;
				ld_bad   = in_acc && is_query && q_bad;
			end
			gpe_pkg::ST_POP: begin
				pop_go = !st_empty;
			end
			gpe_pkg::ST_CHECK: begin
				row_go = !v_hit;
			end
			gpe_pkg::ST_PUSH: begin
				push_go = pick_found;
			end
			gpe_pkg::ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gpe_pkg::ST_IDLE;
			cnt_q      <= gpe_pkg::CNT_RESET;
			depth_q    <= '0;
			row_vld_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				cnt_q <= cfg_data;
			end
			if (in_acc && !is_query && wr_ok) begin
				row_vld_q[wr_row] <= 1'b1;
			end
			if (ld_start) begin
				depth_q <= DW'(1);
			end else if (pop_go) begin
				depth_q <= depth_m1;
			end else if (push_go) begin
				depth_q <= depth_q + DW'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Search and result payload registers.
	always_ff @(posedge clk) begin
		if (ld_start) begin
			visited_q <= src_bit;
			dst_q     <= VW'(in_to);
		end else if (push_go) begin
			visited_q[pick_idx] <= 1'b1;
		end
		// Outcome of the query, held until the result register takes it.
		if (ld_bad) begin
			path_q <= 1'b0;
			bad_q  <= 1'b1;
		end else if (state_q == gpe_pkg::ST_POP && st_empty) begin
			path_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (state_q == gpe_pkg::ST_CHECK && v_hit) begin
			path_q <= 1'b1;
			bad_q  <= 1'b0;
		end
		if (out_load) begin
			m_data_q <= {bad_q, path_q};
		end
	end

	// Adjacency memory: bit write into a live row, whole-row write into a
	// row that still holds its reset contents.
	always_ff @(posedge clk) begin
		if (in_acc && !is_query && wr_ok) begin
			if (row_vld_q[wr_row]) begin
				adj_mem[wr_row][wr_col] <= in_edge;
			end else begin
				adj_mem[wr_row] <= wr_init;
			end
		end
		if (row_go) begin
			adj_rd_q     <= adj_mem[stk_rd_q];
			adj_rd_vld_q <= row_vld_q[stk_rd_q];
		end
	end

	// Stack memory: seeded with the source, then one push or pop per cycle.
	always_ff @(posedge clk) begin
		if (ld_start) begin
			stk_mem[0] <= src_v;
		end else if (push_go) begin
			stk_mem[depth_q[VW-1:0]] <= pick_idx;
		end
		if (pop_go) begin
			stk_rd_q <= stk_mem[depth_m1[VW-1:0]];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, m_data_q};

endmodule
